@@ src/wsp_pkg.sv @@
// Shared types, constants and the microcode table of the wheel speed PID core.
package wsp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd5;

    localparam logic [23:0] GAIN_P_RST    = 24'd131072;
    localparam logic [23:0] GAIN_I_RST    = 24'd32768;
    localparam logic [23:0] GAIN_D_RST    = 24'd6554;
    localparam logic [15:0] STEP_TIME_RST = 16'd655;
    localparam logic [15:0] STEP_RATE_RST = 16'd100;
    localparam logic [9:0]  MAX_SPEED_RST = 10'd100;

    // Command pulse limits and the span they map over
    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;
    localparam logic [9:0]  PULSE_SPAN = 10'd1000;

    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^20
    localparam logic [23:0] RECIP_1000  = 24'd1073742;
    localparam int          RECIP_SHIFT = 30;

    // Saturation limits
    localparam longint LIM32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint LIM32_LO = -64'sh0000_0000_8000_0000;
    localparam longint LIM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LIM48_LO = -64'sh0000_8000_0000_0000;
    localparam longint LIMP_HI  = 64'sh2000_0000_0000_0000;
    localparam longint LIMP_LO  = -64'sh2000_0000_0000_0000;

    // Microcode fields
    typedef logic [3:0] t_step;

    typedef enum logic [2:0] {
        A_PULSE, A_PROD, A_ERR, A_DIFF, A_ILO, A_IHI, A_DLO, A_DHI
    } t_asel;

    typedef enum logic [2:0] {
        B_MAXSPD, B_RECIP, B_STIME, B_SRATE, B_GP, B_GI, B_GD
    } t_bsel;

    typedef enum logic [2:0] {
        CALC_NONE, CALC_ERR, CALC_DIFF, CALC_INTEG, CALC_DERIV
    } t_calc;

    typedef enum logic [1:0] {
        WIDE_NONE, WIDE_PLAIN, WIDE_HI
    } t_wide;

    typedef enum logic [1:0] {
        COND_NONE, COND_IN, COND_OUT
    } t_cond;

    typedef struct packed {
        logic  mul_en;   // load the product register
        t_asel a_sel;
        t_bsel b_sel;
        logic  wr_lo;    // keep low partial product
        t_wide wide_op;  // build the full gain product
        logic  add_en;   // scale, clamp and accumulate the gain product
        t_calc calc;
        t_cond cond;     // hold the step until the handshake allows
        logic  last;     // jump back to the wait step
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        logic  go;
    } t_seq;

    // Program addresses
    localparam t_step ST_WAIT      = 4'd0;
    localparam t_step ST_GOAL_MUL  = 4'd1;
    localparam t_step ST_GOAL_DIV  = 4'd2;
    localparam t_step ST_ERR       = 4'd3;
    localparam t_step ST_INTEG_MUL = 4'd4;
    localparam t_step ST_DERIV_MUL = 4'd5;
    localparam t_step ST_P_MUL     = 4'd6;
    localparam t_step ST_I_LO      = 4'd7;
    localparam t_step ST_I_HI      = 4'd8;
    localparam t_step ST_D_LO      = 4'd9;
    localparam t_step ST_D_HI      = 4'd10;
    localparam t_step ST_D_JOIN    = 4'd11;
    localparam t_step ST_D_ADD     = 4'd12;
    localparam t_step ST_EMIT      = 4'd13;

    localparam t_ctrl CTRL_NOP = '{
        mul_en: 1'b0, a_sel: A_PULSE, b_sel: B_MAXSPD, wr_lo: 1'b0,
        wide_op: WIDE_NONE, add_en: 1'b0, calc: CALC_NONE,
        cond: COND_NONE, last: 1'b0
    };

    // Control store. Multiplies issued in a step read their operands from
    // registers; the product is consumed from the product register later.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl c;
        c = CTRL_NOP;
        case (step)
            ST_WAIT: c.cond = COND_IN;
            ST_GOAL_MUL: begin
                c.mul_en = 1'b1; c.a_sel = A_PULSE; c.b_sel = B_MAXSPD;
            end
            ST_GOAL_DIV: begin
                c.mul_en = 1'b1; c.a_sel = A_PROD; c.b_sel = B_RECIP;
            end
            ST_ERR: c.calc = CALC_ERR;
            ST_INTEG_MUL: begin
                c.mul_en = 1'b1; c.a_sel = A_ERR; c.b_sel = B_STIME;
                c.calc = CALC_DIFF;
            end
            ST_DERIV_MUL: begin
                c.mul_en = 1'b1; c.a_sel = A_DIFF; c.b_sel = B_SRATE;
                c.calc = CALC_INTEG;
            end
            ST_P_MUL: begin
                c.mul_en = 1'b1; c.a_sel = A_ERR; c.b_sel = B_GP;
                c.calc = CALC_DERIV;
            end
            ST_I_LO: begin
                c.mul_en = 1'b1; c.a_sel = A_ILO; c.b_sel = B_GI;
                c.wide_op = WIDE_PLAIN;
            end
            ST_I_HI: begin
                c.mul_en = 1'b1; c.a_sel = A_IHI; c.b_sel = B_GI;
                c.wr_lo = 1'b1; c.add_en = 1'b1;
            end
            ST_D_LO: begin
                c.mul_en = 1'b1; c.a_sel = A_DLO; c.b_sel = B_GD;
                c.wide_op = WIDE_HI;
            end
            ST_D_HI: begin
                c.mul_en = 1'b1; c.a_sel = A_DHI; c.b_sel = B_GD;
                c.wr_lo = 1'b1; c.add_en = 1'b1;
            end
            ST_D_JOIN: c.wide_op = WIDE_HI;
            ST_D_ADD:  c.add_en = 1'b1;
            ST_EMIT: begin
                c.cond = COND_OUT; c.last = 1'b1;
            end
            default: c.last = 1'b1;
        endcase
        return c;
    endfunction

endpackage

@@ src/wsp_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and handshake holds.
module wsp_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    output wsp_pkg::t_seq o_seq
);
    import wsp_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;
    logic  go;

    // Control word of the current step
    assign ctrl = ucode(r_step);

    // A step holds while its handshake condition is not met
    always_comb begin
        case (ctrl.cond)
            COND_NONE: go = 1'b1;
            COND_IN:   go = i_in_valid;
            COND_OUT:  go = i_out_free;
            default:   go = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (go) begin
            n_step = ctrl.last ? ST_WAIT : r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_seq = '{ctrl: ctrl, go: go};

endmodule

@@ src/wsp_datapath.sv @@
// PID datapath: configuration registers, shared multiplier, clamps and state.
module wsp_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wsp_pkg::t_seq                  i_seq,
    input  logic                           i_cfg_valid,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [10:0]                    i_command_pulse,
    input  logic signed [31:0]             i_measured_speed,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_out_free,
    output logic signed [31:0]             o_drive_value,
    output logic                           o_saturated
);
    import wsp_pkg::*;

    localparam int GOAL_W = 10;
    localparam int EW = ((GOAL_W + FRAC_BITS) > 32 ? GOAL_W + FRAC_BITS : 32) + 2;

    // Configuration
    logic [23:0] r_gain_p, r_gain_i, r_gain_d;
    logic [15:0] r_step_time, r_step_rate;
    logic [9:0]  r_max_speed;

    // Item registers and loop state
    logic [9:0]         r_p;
    logic signed [31:0] r_meas;
    logic signed [57:0] r_prod;
    logic signed [31:0] r_err, r_last;
    logic signed [32:0] r_diff;
    logic signed [47:0] r_sum, r_integ, r_deriv;
    logic [47:0]        r_lo;
    logic signed [71:0] r_wide;
    logic signed [63:0] r_acc;
    logic               r_hit;
    logic               r_out_valid;
    logic signed [31:0] r_drive;
    logic               r_sat;

    t_ctrl c;
    logic  accept, emit;

    logic [9:0]         p_in;
    logic signed [32:0] mul_a;
    logic [23:0]        mul_b;
    logic signed [57:0] mul_p;

    logic [GOAL_W-1:0]    goal;
    logic signed [EW-1:0] goal_fx, err_full;
    logic signed [31:0]   err_sat;
    logic                 err_hit;
    logic signed [57:0]   int_full;
    logic signed [47:0]   int_sat, der_sat;
    logic                 int_hit, der_hit;
    logic signed [71:0]   wide_sh;
    logic signed [63:0]   gain_sat;
    logic                 gain_hit;
    logic signed [31:0]   out_sat;
    logic                 out_hit;
    logic                 step_hit;

    assign c      = i_seq.ctrl;
    assign accept = i_seq.go && (c.cond == COND_IN);
    assign emit   = i_seq.go && (c.cond == COND_OUT);

    // Clamp the pulse and remove the offset
    always_comb begin
        if (i_command_pulse < PULSE_MIN) begin
            p_in = '0;
        end else if (i_command_pulse > PULSE_MAX) begin
            p_in = PULSE_SPAN;
        end else begin
            p_in = 10'(i_command_pulse - PULSE_MIN);
        end
    end

    // Shared multiplier operands
    always_comb begin
        case (c.a_sel)
            A_PULSE: mul_a = $signed({23'b0, r_p});
            A_PROD:  mul_a = $signed({13'b0, r_prod[19:0]});
            A_ERR:   mul_a = $signed({r_err[31], r_err});
            A_DIFF:  mul_a = r_diff;
            A_ILO:   mul_a = $signed({9'b0, r_integ[23:0]});
            A_IHI:   mul_a = $signed({{9{r_integ[47]}}, r_integ[47:24]});
            A_DLO:   mul_a = $signed({9'b0, r_deriv[23:0]});
            A_DHI:   mul_a = $signed({{9{r_deriv[47]}}, r_deriv[47:24]});
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (c.b_sel)
            B_MAXSPD: mul_b = {14'b0, r_max_speed};
            B_RECIP:  mul_b = RECIP_1000;
            B_STIME:  mul_b = {8'b0, r_step_time};
            B_SRATE:  mul_b = {8'b0, r_step_rate};
            B_GP:     mul_b = r_gain_p;
            B_GI:     mul_b = r_gain_i;
            B_GD:     mul_b = r_gain_d;
            default:  mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Error: goal in fixed point minus measurement, clamped to 32 bits
    always_comb begin
        goal     = r_prod[RECIP_SHIFT +: GOAL_W];
        goal_fx  = $signed(EW'(goal) << FRAC_BITS);
        err_full = goal_fx - EW'(r_meas);
        err_hit  = 1'b1;
        if (64'(err_full) > LIM32_HI) begin
            err_sat = 32'(LIM32_HI);
        end else if (64'(err_full) < LIM32_LO) begin
            err_sat = 32'(LIM32_LO);
        end else begin
            err_sat = err_full[31:0];
            err_hit = 1'b0;
        end
    end

    // Integrator update, clamped to 48 bits
    always_comb begin
        int_full = (r_prod >>> FRAC_BITS) + 58'(r_sum);
        int_hit  = 1'b1;
        if (int_full > 58'(LIM48_HI)) begin
            int_sat = 48'(LIM48_HI);
        end else if (int_full < 58'(LIM48_LO)) begin
            int_sat = 48'(LIM48_LO);
        end else begin
            int_sat = int_full[47:0];
            int_hit = 1'b0;
        end
    end

    // Derivative, clamped to 48 bits
    always_comb begin
        der_hit = 1'b1;
        if (r_prod > 58'(LIM48_HI)) begin
            der_sat = 48'(LIM48_HI);
        end else if (r_prod < 58'(LIM48_LO)) begin
            der_sat = 48'(LIM48_LO);
        end else begin
            der_sat = r_prod[47:0];
            der_hit = 1'b0;
        end
    end

    // Gain product: floor shift, then clamp to +-2^61
    always_comb begin
        wide_sh  = r_wide >>> FRAC_BITS;
        gain_hit = 1'b1;
        if (wide_sh > 72'(LIMP_HI)) begin
            gain_sat = LIMP_HI;
        end else if (wide_sh < 72'(LIMP_LO)) begin
            gain_sat = LIMP_LO;
        end else begin
            gain_sat = wide_sh[63:0];
            gain_hit = 1'b0;
        end
    end

    // Final output clamp
    always_comb begin
        out_hit = 1'b1;
        if (r_acc > LIM32_HI) begin
            out_sat = 32'(LIM32_HI);
        end else if (r_acc < LIM32_LO) begin
            out_sat = 32'(LIM32_LO);
        end else begin
            out_sat = r_acc[31:0];
            out_hit = 1'b0;
        end
    end

    always_comb begin
        step_hit = 1'b0;
        case (c.calc)
            CALC_ERR:   step_hit = err_hit;
            CALC_INTEG: step_hit = int_hit;
            CALC_DERIV: step_hit = der_hit;
            default:    step_hit = 1'b0;
        endcase
        if (c.add_en) begin
            step_hit = step_hit | gain_hit;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_step_time <= STEP_TIME_RST;
            r_step_rate <= STEP_RATE_RST;
            r_max_speed <= MAX_SPEED_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                CFG_STEP_TIME: r_step_time <= i_cfg_data[15:0];
                CFG_STEP_RATE: r_step_rate <= i_cfg_data[15:0];
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p    <= p_in;
            r_meas <= i_measured_speed;
            r_acc  <= '0;
        end
        if (i_seq.go && c.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_seq.go) begin
            case (c.calc)
                CALC_ERR:   r_err   <= err_sat;
                CALC_DIFF:  r_diff  <= 33'(r_err) - 33'(r_last);
                CALC_INTEG: r_integ <= int_sat;
                CALC_DERIV: r_deriv <= der_sat;
                default: ;
            endcase
            if (c.wr_lo) begin
                r_lo <= r_prod[47:0];
            end
            case (c.wide_op)
                WIDE_PLAIN: r_wide <= 72'(r_prod);
                WIDE_HI:    r_wide <= $signed({r_prod[47:0], 24'b0})
                                    + $signed({24'b0, r_lo});
                default: ;
            endcase
            if (c.add_en) begin
                r_acc <= r_acc + gain_sat;
            end
        end
        if (emit) begin
            r_drive <= out_sat;
            r_sat   <= r_hit | out_hit;
        end
    end

    // Loop state, saturation flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_last      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_hit <= 1'b0;
            end else if (i_seq.go && step_hit) begin
                r_hit <= 1'b1;
            end
            if (emit) begin
                r_sum       <= r_integ;
                r_last      <= r_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_free    = !r_out_valid || i_out_ready;
    assign o_drive_value = r_drive;
    assign o_saturated   = r_sat;

endmodule

@@ src/wheel_speed_pid_core.sv @@
// Top level of the wheel speed PID core.
//
// Each input item (command pulse, measured speed) yields one result item
// (drive value, saturation flag). The result register is loaded in the last
// step of the sequence that runs after an item is accepted, and the next item
// can be taken in the cycle after, so items go one at a time. A microcoded
// sequence issues nine products through one shared 33 x 25 bit multiplier,
// and the 48-bit integral and derivative terms are each split into two
// partial products. A new item is accepted as soon as the sequence returns
// to its wait step, even while the previous result still sits in the output
// register. The result step holds only while that register is full and is
// not being read. Configuration writes are taken in any cycle and should be
// made while no item is in flight. FRAC_BITS sets the binary point of all
// fixed-point values.
module wheel_speed_pid_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [10:0]                    i_command_pulse,
    input  logic signed [31:0]             i_measured_speed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_drive_value,
    output logic                           o_saturated
);
    import wsp_pkg::*;

    t_seq seq;
    logic out_free;

    wsp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_seq      (seq)
    );

    wsp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_seq            (seq),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command_pulse  (i_command_pulse),
        .i_measured_speed (i_measured_speed),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_free       (out_free),
        .o_drive_value    (o_drive_value),
        .o_saturated      (o_saturated)
    );

    // Ready only in the wait step of the program
    assign o_in_ready  = (seq.ctrl.cond == COND_IN);
    assign o_cfg_ready = 1'b1;

endmodule

@@ src/wsp_checker.sv @@
// Port-level checks of the wheel speed PID core, bound to the top level.
module wsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_drive_value,
    input logic        o_saturated
);

    // One item at a time: ready drops right after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after an item was accepted");

    // A new result only appears from the result step, never from the wait step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while waiting for input");

    // A stalled result holds its value and flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_drive_value) && $stable(o_saturated)))
        else $error("stalled result changed or was dropped");

endmodule

bind wheel_speed_pid_core wsp_checker u_wsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_drive_value (o_drive_value),
    .o_saturated   (o_saturated)
);

@@ verif/tb.sv @@
// Self-checking bench for the wheel speed PID core: directed and random commands.
module tb;
    import wsp_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int REPORT_MAX      = 10;
    localparam int SPEED_JITTER    = 1 << 20;

    // Indexes past the register list; writes there must leave the loop untouched
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [10:0]        pulse;
        logic signed [31:0] speed;
    } t_command;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               sat;
    } t_drive;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic [10:0]           command_pulse  = '0;
    logic signed [31:0]    measured_speed = '0;
    logic                  out_ready      = 1'b0;
    logic                  cfg_ready;
    logic                  in_ready;
    logic                  out_valid;
    logic signed [31:0]    drive_value;
    logic                  saturated;

    wheel_speed_pid_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command_pulse (command_pulse),
        .i_measured_speed(measured_speed),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_drive_value   (drive_value),
        .o_saturated     (saturated)
    );

    // Loop settings and state as the bench believes them to be
    logic [23:0] kp, ki, kd;
    logic [15:0] dt_frac, dt_recip;
    logic [9:0]  speed_span;
    longint      integ_acc, last_err;
    bit          limit_hit;

    t_command command_q[$];
    t_drive   drive_expect_q[$];
    t_command held_cmd;

    bit in_idle  = 1'b1;
    bit out_idle = 1'b1;
    int in_gap, out_stall;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int sat_results     = 0;
    int items_sent      = 0;
    int settings_used   = 1;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate to a range, noting any clip for the flag
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            limit_hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            limit_hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // floor(gain * v / 2^FRAC_BITS), split so the product never leaves 64 bits
    function automatic longint gain_scale(input logic [23:0] gain, input longint v);
        longint g, q, r;
        g = longint'(gain);
        q = v >>> FRAC_BITS;
        r = v - (q <<< FRAC_BITS);
        return clip(g * q + ((g * r) >>> FRAC_BITS), LIMP_LO, LIMP_HI);
    endfunction

    // One PID update; advances the integrator and the previous error
    function automatic t_drive pid_update(input t_command c);
        longint pmin, pmax, pspan, span, dt, rate;
        longint pulse, goal, meas, err, integ, deriv, total;
        t_drive res;
        limit_hit = 1'b0;
        pmin  = longint'(PULSE_MIN);
        pmax  = longint'(PULSE_MAX);
        pspan = longint'(PULSE_SPAN);
        span  = longint'(speed_span);
        dt    = longint'(dt_frac);
        rate  = longint'(dt_recip);
        pulse = longint'(c.pulse);
        if (pulse < pmin) pulse = pmin;
        if (pulse > pmax) pulse = pmax;
        goal  = ((pulse - pmin) * span / pspan) <<< FRAC_BITS;
        meas  = longint'($signed(c.speed));
        err   = clip(goal - meas, LIM32_LO, LIM32_HI);
        integ = clip(integ_acc + ((err * dt) >>> FRAC_BITS), LIM48_LO, LIM48_HI);
        deriv = clip((err - last_err) * rate, LIM48_LO, LIM48_HI);
        total = gain_scale(kp, err) + gain_scale(ki, integ) + gain_scale(kd, deriv);
        total = clip(total, LIM32_LO, LIM32_HI);
        integ_acc = integ;
        last_err  = err;
        res.drive = total[31:0];
        res.sat   = limit_hit;
        return res;
    endfunction

    // Register shadow follows every accepted write
    always @(posedge clk) begin
        if (!rst_n) begin
            kp         <= GAIN_P_RST;
            ki         <= GAIN_I_RST;
            kd         <= GAIN_D_RST;
            dt_frac    <= STEP_TIME_RST;
            dt_recip   <= STEP_RATE_RST;
            speed_span <= MAX_SPEED_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GAIN_P:    kp         <= cfg_data;
                CFG_GAIN_I:    ki         <= cfg_data;
                CFG_GAIN_D:    kd         <= cfg_data;
                CFG_STEP_TIME: dt_frac    <= cfg_data[15:0];
                CFG_STEP_RATE: dt_recip   <= cfg_data[15:0];
                CFG_MAX_SPEED: speed_span <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Command driver: predicts on acceptance, then presents the next item after its gap
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            in_gap    = 0;
            integ_acc = 0;
            last_err  = 0;
        end else begin
            if (in_valid && in_ready) begin
                drive_expect_q.push_back(pid_update(held_cmd));
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap--;
                end else if (command_q.size() > 0) begin
                    held_cmd = command_q.pop_front();
                    command_pulse  <= held_cmd.pulse;
                    measured_speed <= held_cmd.speed;
                    in_valid       <= 1'b1;
                    in_gap = in_idle ? $urandom_range(0, 7) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
                     results_checked, what, want, got);
    endtask

    // Result monitor with random back-pressure
    always @(posedge clk) begin
        t_drive want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (drive_expect_q.size() == 0) begin
                    report_mismatch("nothing pending", 0, longint'(drive_value));
                end else begin
                    want = drive_expect_q.pop_front();
                    if (drive_value !== want.drive)
                        report_mismatch("drive_value", longint'(want.drive),
                                        longint'(drive_value));
                    if (saturated !== want.sat)
                        report_mismatch("saturated", longint'(want.sat),
                                        longint'(saturated));
                end
                results_checked++;
                if (saturated) sat_results++;
                out_stall = out_idle ? $urandom_range(0, 7) : 0;
            end else if (out_stall > 0) begin
                out_stall--;
            end
            out_ready <= (out_stall == 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, drive_expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_cmd(input logic [10:0] pulse, input logic [31:0] speed);
        t_command c;
        c.pulse = pulse;
        c.speed = speed;
        command_q.push_back(c);
    endtask

    // Wait until the loop is quiet, then let the sequencer settle
    task automatic drain();
        while (command_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly moderate values, some full-width data (upper bits masked), some extremes
    function automatic logic [23:0] pick_setting(input int unsigned typical,
                                                 input logic [23:0] top);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 24'($urandom_range(0, typical));
        if (sel < 8) return 24'($urandom());
        if (sel == 8) return '0;
        return top;
    endfunction

    initial begin
        logic [23:0] setting;
        logic [9:0]  span;
        logic [10:0] pulse, clamped;
        int          goal_int;
        logic [31:0] speed;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pulse clamping at both ends, error overflow, sign extremes
        queue_cmd(11'd1500, 32'h0000_0000);
        queue_cmd(11'd0,    32'h0000_0000);
        queue_cmd(11'd999,  32'h0001_0000);
        queue_cmd(PULSE_MIN, 32'h0000_0000);
        queue_cmd(PULSE_MAX, 32'h0000_0000);
        queue_cmd(11'd2001, 32'h0000_0000);
        queue_cmd(11'h7FF,  32'h7FFF_FFFF);
        queue_cmd(PULSE_MAX, 32'h8000_0000);
        queue_cmd(PULSE_MIN, 32'h7FFF_FFFF);
        queue_cmd(11'd1234, 32'hFFFF_FFFF);
        queue_cmd(11'd1999, 32'h5555_5555);
        queue_cmd(11'd1001, 32'hAAAA_AAAA);
        drain();

        // Everything at its top; spare indexes must be ignored
        in_idle = 1'b0;
        write_reg(CFG_GAIN_P, 24'hFF_FFFF);
        write_reg(CFG_GAIN_I, 24'hFF_FFFF);
        write_reg(CFG_GAIN_D, 24'hFF_FFFF);
        write_reg(CFG_STEP_TIME, 24'h00_FFFF);
        write_reg(CFG_STEP_RATE, 24'h00_FFFF);
        write_reg(CFG_MAX_SPEED, 24'h00_03FF);
        write_reg(CFG_SPARE_A, 24'h00_0000);
        write_reg(CFG_SPARE_B, 24'hFF_FFFF);
        settings_used++;
        queue_cmd(PULSE_MAX, 32'h8000_0000);
        queue_cmd(PULSE_MIN, 32'h7FFF_FFFF);
        queue_cmd(PULSE_MAX, 32'h8000_0000);
        queue_cmd(11'd1500, 32'h0000_0000);
        queue_cmd(PULSE_MIN, 32'h0000_0000);
        drain();

        // Everything zero: no integration and no derivative term
        out_idle = 1'b0;
        write_reg(CFG_GAIN_P, 24'h00_0000);
        write_reg(CFG_GAIN_I, 24'h00_0000);
        write_reg(CFG_GAIN_D, 24'h00_0000);
        write_reg(CFG_STEP_TIME, 24'h00_0000);
        write_reg(CFG_STEP_RATE, 24'h00_0000);
        write_reg(CFG_MAX_SPEED, 24'h00_0000);
        settings_used++;
        queue_cmd(PULSE_MAX, 32'h1234_5678);
        queue_cmd(11'd0,    32'h8000_0000);
        queue_cmd(11'd1500, 32'h7FFF_FFFF);
        drain();

        // Random settings, each followed by a batch of commands
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            in_idle  = (ph % 3) != 1;
            out_idle = (ph % 3) != 2;
            write_reg(CFG_GAIN_P, pick_setting(262143, 24'hFF_FFFF));
            write_reg(CFG_GAIN_I, pick_setting(262143, 24'hFF_FFFF));
            write_reg(CFG_GAIN_D, pick_setting(65535, 24'hFF_FFFF));
            write_reg(CFG_STEP_TIME, pick_setting(6554, 24'h00_FFFF));
            write_reg(CFG_STEP_RATE, pick_setting(2000, 24'h00_FFFF));
            setting = pick_setting(1023, 24'h00_03FF);
            write_reg(CFG_MAX_SPEED, setting);
            span = setting[9:0];
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          24'($urandom()));
            settings_used++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 6) == 0)
                    pulse = 11'($urandom_range(0, 2047));
                else
                    pulse = 11'($urandom_range(PULSE_MIN, PULSE_MAX));
                clamped = (pulse < PULSE_MIN) ? PULSE_MIN :
                          (pulse > PULSE_MAX) ? PULSE_MAX : pulse;
                // Most speeds sit near the goal so the loop does not just rail
                if ($urandom_range(0, 9) < 7) begin
                    goal_int = (int'(clamped) - int'(PULSE_MIN)) * int'(span)
                               / int'(PULSE_SPAN);
                    speed = (goal_int <<< FRAC_BITS)
                            + int'($urandom_range(0, 2 * SPEED_JITTER)) - SPEED_JITTER;
                end else begin
                    speed = $urandom();
                end
                queue_cmd(pulse, speed);
            end
            drain();
        end

        $display("Sent %0d commands under %0d register settings, idle and back-pressure mixed.",
                 items_sent, settings_used);
        $display("Checked %0d results, %0d of them with the saturation flag set.",
                 results_checked, sat_results);
        if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
